@@ design/assert_macros.svh @@
// Assertion macros for the edit distance design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/levd_pkg.sv @@
// Types, constants and helpers of the edit distance core.
package levd_pkg;

  localparam int MAX_LEN  = 64;
  localparam int LEN_W    = $clog2(MAX_LEN + 1);
  localparam int COL_W    = LEN_W;
  localparam int SYM_W    = 8;
  localparam int DIST_W   = 7;
  localparam int DIST_MAX = 127;

  localparam logic CMD_FIRST  = 1'b0;
  localparam logic CMD_SECOND = 1'b1;

  typedef struct packed {
    logic             command;
    logic [SYM_W-1:0] symbol;
    logic             is_last;
    logic             is_empty;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } result_t;

  // One step of the wavefront travelling along the cell row.
  typedef struct packed {
    logic             valid;
    logic [SYM_W-1:0] ch;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] diag;
  } wave_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic             flush;
    logic             load;
    logic [LEN_W-1:0] load_rank;
    logic [SYM_W-1:0] load_sym;
    logic             init;
    logic [LEN_W-1:0] init_len;
  } cell_ctrl_t;

  function automatic logic [COL_W-1:0] min3(input logic [COL_W-1:0] a,
                                            input logic [COL_W-1:0] b,
                                            input logic [COL_W-1:0] c);
    logic [COL_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic logic [DIST_W-1:0] saturate_dist(input logic [COL_W-1:0] v);
    if (int'(v) > DIST_MAX) begin
      return DIST_W'(DIST_MAX);
    end
    return DIST_W'(v);
  endfunction

endpackage

@@ design/levenshtein_edit_distance_core.sv @@
// Top level of the edit distance core: sequencer, cell row and result register.
//
//   channel  | direction | handshake                  | word
//   item     | in        | item_valid / item_ready    | levd_pkg::item_t
//   result   | out       | result_valid / result_ready| levd_pkg::result_t
//
// Cycles: one word of either string per cycle while running; each second-string
// character enters the cell row and moves one cell a cycle as a wavefront.
// After the word that ends the second string, item_ready stays low while the
// wavefront crosses all MAX_LEN cells and reaches the tail.
// The result then loads as soon as the result register is free; a waiting
// result does not block further words until the next pair ends.
// Reset: rst, synchronous; clears sequencer state and the cell active and valid bits only.
`include "assert_macros.svh"

module levenshtein_edit_distance_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  levd_pkg::item_t      item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output levd_pkg::result_t    result
);

  localparam int DRAIN_W = $clog2(levd_pkg::MAX_LEN + 2);

  typedef enum logic [1:0] {
    ST_RUN   = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t                          state;
  logic [DRAIN_W-1:0]              drain_cnt;
  logic [levd_pkg::LEN_W-1:0]      first_length;
  logic [levd_pkg::LEN_W-1:0]      second_index;
  logic                            first_done;
  logic                            overflow_seen;
  logic [levd_pkg::COL_W-1:0]      tail_val;

  // Entry register of the cell row.
  logic                            wave0_valid;
  logic [levd_pkg::SYM_W-1:0]      wave0_ch;
  logic [levd_pkg::COL_W-1:0]      wave0_left;
  logic [levd_pkg::COL_W-1:0]      wave0_diag;

  levd_pkg::wave_t                 waves [0:levd_pkg::MAX_LEN];
  levd_pkg::cell_ctrl_t            cell_ctrl;

  logic                            accept;
  logic                            take_first;
  logic                            take_second;
  logic                            restart;
  logic                            store;
  logic                            finish;
  logic                            advance;
  logic                            ends_pair;
  logic                            fire;
  logic [levd_pkg::LEN_W-1:0]      len_base;
  logic [levd_pkg::LEN_W-1:0]      len_after;
  logic                            ov_next;

  assign item_ready  = (state == ST_RUN);
  assign accept      = item_valid && item_ready;
  assign take_first  = accept && (item.command == levd_pkg::CMD_FIRST);
  assign take_second = accept && (item.command == levd_pkg::CMD_SECOND) && first_done;

  // A first-string word after a complete first string abandons the pair.
  assign restart  = take_first && first_done;
  assign len_base = restart ? '0 : first_length;
  assign store    = take_first && !item.is_empty && (int'(len_base) < levd_pkg::MAX_LEN);
  assign finish   = take_first && (item.is_empty || item.is_last);

  always_comb begin
    if (item.is_empty) begin
      len_after = '0;
    end else if (store) begin
      len_after = len_base + levd_pkg::LEN_W'(1);
    end else begin
      len_after = len_base;
    end
  end

  assign advance   = take_second && !item.is_empty &&
                     (int'(second_index) < levd_pkg::MAX_LEN);
  assign ends_pair = take_second && (item.is_empty || item.is_last);
  assign fire      = (state == ST_DRAIN) && (drain_cnt == '0) &&
                     (!result_valid || result_ready);

  // Truncation: drop the character, remember it for the result.
  always_comb begin
    ov_next = restart ? 1'b0 : overflow_seen;
    if (take_first && !item.is_empty && !store) begin
      ov_next = 1'b1;
    end
    if (take_second && !item.is_empty && !advance) begin
      ov_next = 1'b1;
    end
  end

  // Broadcast to the row: flush drops stale characters and in-flight steps.
  assign cell_ctrl = '{
    flush:     restart || fire || (take_first && item.is_empty),
    load:      store,
    load_rank: len_base + levd_pkg::LEN_W'(1),
    load_sym:  item.symbol,
    init:      finish,
    init_len:  len_after
  };

  assign waves[0] = '{valid: wave0_valid, ch: wave0_ch, left: wave0_left, diag: wave0_diag};

  for (genvar g = 0; g < levd_pkg::MAX_LEN; g++) begin : g_cell
    levd_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .rank     (levd_pkg::LEN_W'(g + 1)),
      .ctrl     (cell_ctrl),
      .wave_in  (waves[g]),
      .wave_out (waves[g + 1])
    );
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_RUN;
      drain_cnt     <= '0;
      first_length  <= '0;
      second_index  <= '0;
      first_done    <= 1'b0;
      overflow_seen <= 1'b0;
      wave0_valid   <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      wave0_valid <= advance;

      if (fire) begin
        first_length  <= '0;
        second_index  <= '0;
        first_done    <= 1'b0;
        overflow_seen <= 1'b0;
      end else begin
        overflow_seen <= ov_next;
        if (take_first) begin
          first_length <= len_after;
        end
        if (finish) begin
          first_done   <= 1'b1;
          second_index <= '0;
        end else if (restart) begin
          first_done   <= 1'b0;
          second_index <= '0;
        end else if (advance) begin
          second_index <= second_index + levd_pkg::LEN_W'(1);
        end
      end

      case (state)
        ST_RUN: begin
          if (ends_pair) begin
            state     <= ST_DRAIN;
            drain_cnt <= DRAIN_W'(levd_pkg::MAX_LEN + 1);
          end
        end
        ST_DRAIN: begin
          if (drain_cnt != '0) begin
            drain_cnt <= drain_cnt - DRAIN_W'(1);
          end else if (fire) begin
            state <= ST_RUN;
          end
        end
        default: begin
          state <= ST_RUN;
        end
      endcase

      if (fire) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload: entry step of the wavefront, tail value and result word.
  always_ff @(posedge clk) begin
    wave0_ch   <= item.symbol;
    wave0_left <= second_index + levd_pkg::COL_W'(1);
    wave0_diag <= second_index;

    // Hold the last cell's value; an empty second string leaves the length.
    if (finish) begin
      tail_val <= len_after;
    end else if (waves[levd_pkg::MAX_LEN].valid) begin
      tail_val <= waves[levd_pkg::MAX_LEN].left;
    end

    if (fire) begin
      result <= '{distance: levd_pkg::saturate_dist(tail_val), overflow: overflow_seen};
    end
  end

  `ASSERT_IMPLIES(a_len_bound, 1'b1, int'(first_length) <= levd_pkg::MAX_LEN, "first length out of range")
  `ASSERT_IMPLIES(a_idx_bound, 1'b1, int'(second_index) <= levd_pkg::MAX_LEN, "second index out of range")
  `ASSERT_IMPLIES(a_wave_in_pair, wave0_valid, first_done, "wavefront step outside a pair")
  `ASSERT_IMPLIES(a_run_idle_cnt, state == ST_RUN, drain_cnt == '0, "drain counter busy while running")
  `ASSERT_NEXT(a_fire_clears, fire, result_valid && !first_done && second_index == '0, "pair not cleared after result")

endmodule

@@ design/levd_cell.sv @@
// One cell of the row: a first-string character and one column entry.
module levd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [levd_pkg::LEN_W-1:0]     rank,
  input  levd_pkg::cell_ctrl_t           ctrl,
  input  levd_pkg::wave_t                wave_in,
  output levd_pkg::wave_t                wave_out
);

  logic [levd_pkg::SYM_W-1:0] sym;
  logic                       active;
  logic [levd_pkg::COL_W-1:0] val;
  logic [levd_pkg::COL_W-1:0] val_next;
  logic [levd_pkg::COL_W-1:0] init_val;
  logic                       hit;

  logic                       out_valid;
  logic [levd_pkg::SYM_W-1:0] out_ch;
  logic [levd_pkg::COL_W-1:0] out_left;
  logic [levd_pkg::COL_W-1:0] out_diag;

  assign hit      = ctrl.load && (ctrl.load_rank == rank);
  assign init_val = (rank <= ctrl.init_len) ? rank : ctrl.init_len;

  // Past the end of the first string, pass the left value straight on.
  always_comb begin
    if (!active) begin
      val_next = wave_in.left;
    end else if (sym == wave_in.ch) begin
      val_next = wave_in.diag;
    end else begin
      val_next = levd_pkg::min3(val, wave_in.left, wave_in.diag) + levd_pkg::COL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (hit) begin
        active <= 1'b1;
      end else if (ctrl.flush) begin
        active <= 1'b0;
      end
      out_valid <= wave_in.valid && !ctrl.flush && !ctrl.init;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      sym <= ctrl.load_sym;
    end
    if (ctrl.init) begin
      val <= init_val;
    end else if (wave_in.valid) begin
      val <= val_next;
    end
    out_ch   <= wave_in.ch;
    out_left <= val_next;
    out_diag <= val;
  end

  assign wave_out = '{valid: out_valid, ch: out_ch, left: out_left, diag: out_diag};

endmodule
